### src/lcdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD controller package
// Shared types, codes and default sizes for the LCD command and RAM unit.
// ----------------------------------------------------------------------------
package lcdc_pkg;

    // Default geometry: last column index and number of full data pages
    localparam int LAST_COLUMN_DEF = 131;
    localparam int DATA_PAGES_DEF  = 8;

    // Pointer widths fixed by the command set
    localparam int COL_W  = 8;
    localparam int PAGE_W = 4;

    // Electric volume register value after reset
    localparam logic [5:0] VOLUME_RESET = 6'h20;

    // Entries in the queue between decoder and executor (power of two)
    localparam int QUEUE_DEPTH = 2;

    // Single-byte command codes
    localparam logic [7:0] BYTE_RMW_BEGIN = 8'hE0;
    localparam logic [7:0] BYTE_RMW_END   = 8'hEE;
    localparam logic [7:0] BYTE_VOLUME    = 8'h81;

    // Kind of bus access
    typedef enum logic [1:0] {
        OP_WR_DATA,
        OP_WR_CMD,
        OP_RD_DATA,
        OP_RD_STATUS
    } op_t;

    // Decoded command byte
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_DISPLAY,
        CMD_START_LINE,
        CMD_COL_LO,
        CMD_COL_HI,
        CMD_RATIO,
        CMD_POWER,
        CMD_PAGE,
        CMD_SEG_REV,
        CMD_INVERT,
        CMD_ALL_ON,
        CMD_BIAS,
        CMD_INDICATOR,
        CMD_RMW_BEGIN,
        CMD_RMW_END,
        CMD_COM_REV,
        CMD_VOLUME
    } cmd_t;

    // One bus access as it arrives
    typedef struct packed {
        logic       mode;
        logic       reg_select;
        logic [7:0] write_data;
    } item_t;

    // One result beat
    typedef struct packed {
        logic [7:0] read_data;
        logic       display_on;
        logic       all_pixels_on;
        logic [5:0] first_line;
        logic       segment_reverse;
        logic       com_reverse;
        logic [5:0] contrast_level;
    } result_t;

    // Classified access held in the queue
    typedef struct packed {
        op_t        op;
        cmd_t       cmd;
        logic [7:0] data;
    } entry_t;

    // Queue fill status
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

### src/lcdc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD controller front end
// Accepts bus accesses, classifies port and direction, decodes command bytes
// and hands the classified entry to the queue.
// ----------------------------------------------------------------------------
module lcdc_front
    import lcdc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  item_t     bus_access,
    input  logic      hold,
    input  q_status_t q_status,
    output logic      busy,
    output logic      push,
    output entry_t    push_entry
);

    logic   stage_valid_reg;
    logic   stage_valid_next;
    entry_t stage_entry_reg;
    logic   accept;

    // Decode one command byte into its command code
    function automatic cmd_t decode_cmd(input logic [7:0] d);
        cmd_t c;
        c = CMD_NONE;
        if (d inside {8'hAE, 8'hAF})                  c = CMD_DISPLAY;
        else if (d inside {[8'h40:8'h7F]})             c = CMD_START_LINE;
        else if (d inside {[8'h00:8'h0F]})             c = CMD_COL_LO;
        else if (d inside {[8'h10:8'h1F]})             c = CMD_COL_HI;
        else if (d inside {[8'h20:8'h27]})             c = CMD_RATIO;
        else if (d inside {[8'h28:8'h2F]})             c = CMD_POWER;
        else if (d inside {[8'hB0:8'hBF]})             c = CMD_PAGE;
        else if (d inside {8'hA0, 8'hA1})              c = CMD_SEG_REV;
        else if (d inside {8'hA6, 8'hA7})              c = CMD_INVERT;
        else if (d inside {8'hA4, 8'hA5})              c = CMD_ALL_ON;
        else if (d inside {8'hA2, 8'hA3})              c = CMD_BIAS;
        else if (d inside {8'hAC, 8'hAD})              c = CMD_INDICATOR;
        else if (d == BYTE_RMW_BEGIN)                  c = CMD_RMW_BEGIN;
        else if (d == BYTE_RMW_END)                    c = CMD_RMW_END;
        else if (d inside {[8'hC0:8'hCF]})             c = CMD_COM_REV;
        else if (d == BYTE_VOLUME)                     c = CMD_VOLUME;
        return c;
    endfunction

    // Stall new beats while the RAM clears or the staged entry cannot move
    assign busy   = hold | (stage_valid_reg & q_status.full);
    assign accept = start & ~busy;

    // Hand the staged entry to the queue when there is room
    assign push       = stage_valid_reg & ~q_status.full;
    assign push_entry = stage_entry_reg;

    always_comb
    begin
        stage_valid_next = accept | (stage_valid_reg & q_status.full);
    end

    // Hold the valid flag of the staging register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Classify the accepted beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_entry_reg.data <= bus_access.write_data;
            stage_entry_reg.cmd  <= decode_cmd(bus_access.write_data);
            if (bus_access.mode)
            begin
                stage_entry_reg.op <= bus_access.reg_select ? OP_RD_STATUS : OP_RD_DATA;
            end
            else
            begin
                stage_entry_reg.op <= bus_access.reg_select ? OP_WR_CMD : OP_WR_DATA;
            end
        end
    end

endmodule

### src/lcdc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD controller entry queue
// Short first-in first-out buffer between the decoder and the executor.
// ----------------------------------------------------------------------------
module lcdc_queue
    import lcdc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  entry_t    push_entry,
    input  logic      pop,
    output entry_t    pop_entry,
    output q_status_t q_status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign q_status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign pop_entry      = slots_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### src/lcdc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD controller executor
// Applies queued accesses to the controller registers and the display RAM,
// clears the RAM after reset and registers one result beat per access.
// ----------------------------------------------------------------------------
module lcdc_back
    import lcdc_pkg::*;
#(
    parameter int LAST_COLUMN = LAST_COLUMN_DEF,
    parameter int DATA_PAGES  = DATA_PAGES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_status_t q_status,
    input  entry_t    pop_entry,
    output logic      pop,
    output logic      clearing,
    output logic      done,
    output result_t   result
);

    localparam int COLS      = LAST_COLUMN + 1;
    localparam int RAM_DEPTH = (DATA_PAGES + 1) * COLS;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);

    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(LAST_COLUMN);
    localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(DATA_PAGES);

    // Display RAM
    logic [7:0]        ram [RAM_DEPTH];
    logic [7:0]        ram_q_reg;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [ADDR_W-1:0] exec_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        data_wdata;
    logic              data_we;

    // Clear sweep
    logic              clearing_reg;
    logic              clearing_next;
    logic [ADDR_W-1:0] clear_addr_reg;
    logic [ADDR_W-1:0] clear_addr_next;

    // Controller registers
    logic [COL_W-1:0]  column_reg;
    logic [COL_W-1:0]  column_next;
    logic [PAGE_W-1:0] page_reg;
    logic [PAGE_W-1:0] page_next;
    logic [5:0]        start_line_reg;
    logic [5:0]        start_line_next;
    logic              enable_reg;
    logic              enable_next;
    logic              all_on_reg;
    logic              all_on_next;
    logic              seg_rev_reg;
    logic              seg_rev_next;
    logic              com_rev_reg;
    logic              com_rev_next;
    logic              rmw_reg;
    logic              rmw_next;
    logic [5:0]        volume_reg;
    logic [5:0]        volume_next;
    logic              vol_pend_reg;
    logic              vol_pend_next;

    // Result snapshot
    logic              done_reg;
    logic              rd_sel_reg;
    result_t           snap_reg;

    logic [COL_W-1:0]  col_adv;
    logic [COL_W-1:0]  col_lo_val;
    logic [COL_W-1:0]  col_hi_val;

    assign clearing = clearing_reg;
    assign pop      = ~q_status.empty & ~clearing_reg;

    // RAM address of the current page and column
    assign exec_addr = ADDR_W'(page_reg) * ADDR_W'(COLS) + ADDR_W'(column_reg);

    // Column after an access; stop at the last column
    assign col_adv    = (column_reg < LAST_COL) ? column_reg + 1'b1 : column_reg;
    assign col_lo_val = {column_reg[7:4], pop_entry.data[3:0]};
    assign col_hi_val = {pop_entry.data[3:0], column_reg[3:0]};

    // Indicator page keeps bit 0 only
    assign data_wdata = (page_reg >= LAST_PAGE) ? {7'b0, pop_entry.data[0]}
                                                : pop_entry.data;

    // Execute the popped access
    always_comb
    begin
        column_next     = column_reg;
        page_next       = page_reg;
        start_line_next = start_line_reg;
        enable_next     = enable_reg;
        all_on_next     = all_on_reg;
        seg_rev_next    = seg_rev_reg;
        com_rev_next    = com_rev_reg;
        rmw_next        = rmw_reg;
        volume_next     = volume_reg;
        vol_pend_next   = vol_pend_reg;
        data_we         = 1'b0;
        ram_re          = 1'b0;
        if (pop)
        begin
            case (pop_entry.op)
                OP_RD_DATA:
                begin
                    ram_re = 1'b1;
                    if (!rmw_reg)
                    begin
                        column_next = col_adv;
                    end
                end
                OP_RD_STATUS:
                begin
                end
                OP_WR_DATA, OP_WR_CMD:
                begin
                    if (vol_pend_reg)
                    begin
                        // Second byte of the volume command
                        volume_next   = pop_entry.data[5:0];
                        vol_pend_next = 1'b0;
                    end
                    else if (pop_entry.op == OP_WR_DATA)
                    begin
                        data_we     = 1'b1;
                        column_next = col_adv;
                    end
                    else
                    begin
                        case (pop_entry.cmd)
                            CMD_DISPLAY:    enable_next     = pop_entry.data[0];
                            CMD_START_LINE: start_line_next = pop_entry.data[5:0];
                            CMD_COL_LO:
                                column_next = (col_lo_val > LAST_COL) ? LAST_COL : col_lo_val;
                            CMD_COL_HI:
                                column_next = (col_hi_val > LAST_COL) ? LAST_COL : col_hi_val;
                            CMD_PAGE:
                                page_next = (pop_entry.data[3:0] > LAST_PAGE)
                                          ? LAST_PAGE : pop_entry.data[3:0];
                            CMD_SEG_REV:    seg_rev_next    = pop_entry.data[0];
                            CMD_ALL_ON:     all_on_next     = pop_entry.data[0];
                            CMD_RMW_BEGIN:  rmw_next        = 1'b1;
                            CMD_RMW_END:    rmw_next        = 1'b0;
                            CMD_COM_REV:    com_rev_next    = pop_entry.data[3];
                            CMD_VOLUME:     vol_pend_next   = 1'b1;
                            // Ratio, power, invert, bias and indicator settings
                            // do not reach the outputs; drop them
                            default:
                            begin
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Step the clear sweep through every RAM entry
    always_comb
    begin
        clearing_next   = clearing_reg;
        clear_addr_next = clear_addr_reg;
        if (clearing_reg)
        begin
            clear_addr_next = clear_addr_reg + 1'b1;
            if (clear_addr_reg == ADDR_W'(RAM_DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    // Pick the RAM port between the sweep and the executor
    assign ram_we    = clearing_reg | data_we;
    assign ram_addr  = clearing_reg ? clear_addr_reg : exec_addr;
    assign ram_wdata = clearing_reg ? 8'h00 : data_wdata;

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            ram[ram_addr] <= ram_wdata;
        end
        if (ram_re)
        begin
            ram_q_reg <= ram[ram_addr];
        end
    end

    // Update control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
            column_reg     <= '0;
            page_reg       <= '0;
            start_line_reg <= '0;
            enable_reg     <= 1'b0;
            all_on_reg     <= 1'b0;
            seg_rev_reg    <= 1'b0;
            com_rev_reg    <= 1'b0;
            rmw_reg        <= 1'b0;
            volume_reg     <= VOLUME_RESET;
            vol_pend_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            clearing_reg   <= clearing_next;
            clear_addr_reg <= clear_addr_next;
            column_reg     <= column_next;
            page_reg       <= page_next;
            start_line_reg <= start_line_next;
            enable_reg     <= enable_next;
            all_on_reg     <= all_on_next;
            seg_rev_reg    <= seg_rev_next;
            com_rev_reg    <= com_rev_next;
            rmw_reg        <= rmw_next;
            volume_reg     <= volume_next;
            vol_pend_reg   <= vol_pend_next;
            done_reg       <= pop;
        end
    end

    // Capture the state after the access for its result beat
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_sel_reg               <= ram_re;
            snap_reg.read_data       <= 8'h00;
            snap_reg.display_on      <= enable_next;
            snap_reg.all_pixels_on   <= all_on_next;
            snap_reg.first_line      <= start_line_next;
            snap_reg.segment_reverse <= seg_rev_next;
            snap_reg.com_reverse     <= com_rev_next;
            snap_reg.contrast_level  <= volume_next;
        end
    end

    assign done = done_reg;

    always_comb
    begin
        result           = snap_reg;
        result.read_data = rd_sel_reg ? ram_q_reg : 8'h00;
    end

    // The executor never takes an entry while the RAM is being cleared
    a_no_pop_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !pop)
        else $error("entry executed during RAM clear");

    // A result beat follows exactly one executed entry
    a_done_after_pop : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(pop))
        else $error("result beat without executed entry");

    // Pointers stay inside the display area
    a_pointer_range : assert property (@(posedge clk) disable iff (!rst_n)
        (column_reg <= LAST_COL) && (page_reg <= LAST_PAGE))
        else $error("RAM pointer out of range");

    // Once the sweep ends it does not restart
    a_clear_once : assert property (@(posedge clk) disable iff (!rst_n)
        !clearing_reg |=> !clearing_reg)
        else $error("RAM clear restarted");

endmodule

### src/lcd_controller_command_and_ram_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD controller command and RAM unit
// Bus interface of a graphic LCD controller: command decode, display RAM
// access with column auto-increment, and one status beat per access.
// ----------------------------------------------------------------------------
//  channel   handshake         payload      direction
//  access    start / busy      bus_access   in
//  result    done (strobe)     result       out
//
//  An accepted access passes the staging register, the queue and the
//  executor with its registered RAM read on its way to its result beat.
//  A new access may be accepted at every edge while busy is low.
//  After reset the RAM is swept to zero, one byte per cycle, over all
//  (DATA_PAGES+1)*(LAST_COLUMN+1) bytes (1188 by default); busy is high.
//  Result beats cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module lcd_controller_command_and_ram_unit
    import lcdc_pkg::*;
#(
    parameter int LAST_COLUMN = LAST_COLUMN_DEF,
    parameter int DATA_PAGES  = DATA_PAGES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   bus_access,
    output logic    done,
    output result_t result
);

    q_status_t q_status;
    logic      push;
    entry_t    push_entry;
    logic      pop;
    entry_t    pop_entry;
    logic      clearing;

    lcdc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .bus_access (bus_access),
        .hold       (clearing),
        .q_status   (q_status),
        .busy       (busy),
        .push       (push),
        .push_entry (push_entry)
    );

    lcdc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_status   (q_status)
    );

    lcdc_back #(
        .LAST_COLUMN (LAST_COLUMN),
        .DATA_PAGES  (DATA_PAGES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_entry (pop_entry),
        .pop       (pop),
        .clearing  (clearing),
        .done      (done),
        .result    (result)
    );

endmodule

### bench/lcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD controller status checker
// Watches the access and result channels of the LCD command and RAM unit,
// keeps its own copy of the controller registers and display RAM, predicts
// the status beat of every accepted access and compares it field by field.
// ----------------------------------------------------------------------------

// Command opcode bases and decode masks shared by the checker and the stimulus
package lcdc_tb_pkg;

    localparam logic [7:0] OPC_COL_LO     = 8'h00;
    localparam logic [7:0] OPC_COL_HI     = 8'h10;
    localparam logic [7:0] OPC_RATIO      = 8'h20;
    localparam logic [7:0] OPC_POWER      = 8'h28;
    localparam logic [7:0] OPC_START_LINE = 8'h40;
    localparam logic [7:0] OPC_SEG_REV    = 8'hA0;
    localparam logic [7:0] OPC_BIAS       = 8'hA2;
    localparam logic [7:0] OPC_ALL_ON     = 8'hA4;
    localparam logic [7:0] OPC_INVERT     = 8'hA6;
    localparam logic [7:0] OPC_INDICATOR  = 8'hAC;
    localparam logic [7:0] OPC_DISPLAY    = 8'hAE;
    localparam logic [7:0] OPC_PAGE       = 8'hB0;
    localparam logic [7:0] OPC_COM_REV    = 8'hC0;
    // Undecoded byte that sits next to the read-modify-write codes
    localparam logic [7:0] OPC_IGNORED    = 8'hE3;

    localparam logic [7:0] MASK_FLAG   = 8'hFE;
    localparam logic [7:0] MASK_NIBBLE = 8'hF0;
    localparam logic [7:0] MASK_TRIPLE = 8'hF8;
    localparam logic [7:0] MASK_LINE   = 8'hC0;

endpackage

module lcd_checker
    import lcdc_pkg::*;
    import lcdc_tb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  item_t   bus_access,
    input  logic    done,
    input  result_t result,
    output int      errors,
    output int      outstanding
);

    localparam int COLS      = LAST_COLUMN_DEF + 1;
    localparam int RAM_BYTES = COLS * (DATA_PAGES_DEF + 1);

    // Shadow copy of the controller state
    logic [7:0]        pixel_ram [RAM_BYTES];
    logic [COL_W-1:0]  col_ptr;
    logic [PAGE_W-1:0] page_ptr;
    logic [5:0]        line_reg;
    logic              enable_flag;
    logic              all_on_flag;
    logic              seg_rev_flag;
    logic              invert_flag;
    logic              com_rev_flag;
    logic              bias_flag;
    logic              indicator_flag;
    logic              rmw_flag;
    logic [5:0]        volume_reg;
    logic              volume_pending;
    logic [2:0]        ratio_reg;
    logic [2:0]        power_reg;
    logic [7:0]        last_written;

    result_t expected_status [$];
    int      results_seen;

    // Classify a command byte; first match wins
    function automatic cmd_t decode_command(input logic [7:0] b);
        if ((b & MASK_FLAG) == OPC_DISPLAY)        return CMD_DISPLAY;
        if ((b & MASK_LINE) == OPC_START_LINE)     return CMD_START_LINE;
        if ((b & MASK_NIBBLE) == OPC_COL_LO)       return CMD_COL_LO;
        if ((b & MASK_NIBBLE) == OPC_COL_HI)       return CMD_COL_HI;
        if ((b & MASK_TRIPLE) == OPC_RATIO)        return CMD_RATIO;
        if ((b & MASK_TRIPLE) == OPC_POWER)        return CMD_POWER;
        if ((b & MASK_NIBBLE) == OPC_PAGE)         return CMD_PAGE;
        if ((b & MASK_FLAG) == OPC_SEG_REV)        return CMD_SEG_REV;
        if ((b & MASK_FLAG) == OPC_INVERT)         return CMD_INVERT;
        if ((b & MASK_FLAG) == OPC_ALL_ON)         return CMD_ALL_ON;
        if ((b & MASK_FLAG) == OPC_BIAS)           return CMD_BIAS;
        if ((b & MASK_FLAG) == OPC_INDICATOR)      return CMD_INDICATOR;
        if (b == BYTE_RMW_BEGIN)                   return CMD_RMW_BEGIN;
        if (b == BYTE_RMW_END)                     return CMD_RMW_END;
        if ((b & MASK_NIBBLE) == OPC_COM_REV)      return CMD_COM_REV;
        if (b == BYTE_VOLUME)                      return CMD_VOLUME;
        return CMD_NONE;
    endfunction

    // Saturate a column value at the last column
    function automatic logic [COL_W-1:0] clamp_column(input logic [COL_W-1:0] v);
        return (v > LAST_COLUMN_DEF) ? COL_W'(LAST_COLUMN_DEF) : v;
    endfunction

    // Apply one access to the shadow state and build its status beat
    task automatic predict_access(input item_t acc, output result_t status);
        op_t        op;
        logic [7:0] d;
        logic [7:0] rd;
        int         idx;
        op  = acc.mode ? (acc.reg_select ? OP_RD_STATUS : OP_RD_DATA)
                       : (acc.reg_select ? OP_WR_CMD : OP_WR_DATA);
        d   = acc.write_data;
        rd  = '0;
        idx = int'(page_ptr) * COLS + int'(col_ptr);
        if (idx >= RAM_BYTES)
            idx = 0;
        case (op)
            OP_RD_STATUS: ;
            OP_RD_DATA:
            begin
                rd = pixel_ram[idx];
                if (!rmw_flag && col_ptr < LAST_COLUMN_DEF)
                    col_ptr++;
            end
            default:
            begin
                last_written = d;
                if (volume_pending)
                begin
                    // second byte of the volume command, nothing else
                    volume_reg     = d[5:0];
                    volume_pending = 1'b0;
                end
                else if (op == OP_WR_CMD)
                begin
                    case (decode_command(d))
                        CMD_DISPLAY:    enable_flag    = d[0];
                        CMD_START_LINE: line_reg       = d[5:0];
                        CMD_COL_LO:     col_ptr        = clamp_column({col_ptr[7:4], d[3:0]});
                        CMD_COL_HI:     col_ptr        = clamp_column({d[3:0], col_ptr[3:0]});
                        CMD_RATIO:      ratio_reg      = d[2:0];
                        CMD_POWER:      power_reg      = d[2:0];
                        CMD_PAGE:       page_ptr       = (d[3:0] > DATA_PAGES_DEF)
                                                         ? PAGE_W'(DATA_PAGES_DEF) : d[3:0];
                        CMD_SEG_REV:    seg_rev_flag   = d[0];
                        CMD_INVERT:     invert_flag    = d[0];
                        CMD_ALL_ON:     all_on_flag    = d[0];
                        CMD_BIAS:       bias_flag      = d[0];
                        CMD_INDICATOR:  indicator_flag = d[0];
                        CMD_RMW_BEGIN:  rmw_flag       = 1'b1;
                        CMD_RMW_END:    rmw_flag       = 1'b0;
                        CMD_COM_REV:    com_rev_flag   = d[3];
                        CMD_VOLUME:     volume_pending = 1'b1;
                        default: ;
                    endcase
                end
                else
                begin
                    // indicator page keeps bit 0 only
                    if (page_ptr >= DATA_PAGES_DEF)
                        d = {7'b0, d[0]};
                    pixel_ram[idx] = d;
                    if (col_ptr < LAST_COLUMN_DEF)
                        col_ptr++;
                end
            end
        endcase
        status.read_data       = rd;
        status.display_on      = enable_flag;
        status.all_pixels_on   = all_on_flag;
        status.first_line      = line_reg;
        status.segment_reverse = seg_rev_flag;
        status.com_reverse     = com_rev_flag;
        status.contrast_level  = volume_reg;
    endtask

    // Count a field mismatch, report the first few
    task automatic check_field(input string field, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            errors++;
            if (errors <= 10)
                $display("status beat %0d: %s expected 0x%0h, got 0x%0h",
                         results_seen, field, want_v, got_v);
        end
    endtask

    // Predict on each accepted access, compare each result beat
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < RAM_BYTES; i++)
                pixel_ram[i] = '0;
            col_ptr        = '0;
            page_ptr       = '0;
            line_reg       = '0;
            enable_flag    = 1'b0;
            all_on_flag    = 1'b0;
            seg_rev_flag   = 1'b0;
            invert_flag    = 1'b0;
            com_rev_flag   = 1'b0;
            bias_flag      = 1'b0;
            indicator_flag = 1'b0;
            rmw_flag       = 1'b0;
            volume_reg     = VOLUME_RESET;
            volume_pending = 1'b0;
            ratio_reg      = '0;
            power_reg      = '0;
            last_written   = '0;
            expected_status.delete();
            results_seen   = 0;
            errors         = 0;
            outstanding   <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_access(bus_access, want);
                expected_status.push_back(want);
            end
            if (done)
            begin
                results_seen++;
                if (expected_status.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("status beat %0d arrived with nothing pending: 0x%0h",
                                 results_seen, result);
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("read_data", want.read_data, result.read_data);
                    check_field("display_on", want.display_on, result.display_on);
                    check_field("all_pixels_on", want.all_pixels_on, result.all_pixels_on);
                    check_field("first_line", want.first_line, result.first_line);
                    check_field("segment_reverse", want.segment_reverse,
                                result.segment_reverse);
                    check_field("com_reverse", want.com_reverse, result.com_reverse);
                    check_field("contrast_level", want.contrast_level,
                                result.contrast_level);
                end
            end
            outstanding <= expected_status.size();
        end
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD command and RAM unit testbench
// Drives bus accesses (command writes, data writes, data and status reads)
// into the unit: a directed opening, then randomized cursor, burst,
// read-modify-write, volume, flag and noise sequences under several sender
// idle rates. The checker predicts and compares every status beat.
// ----------------------------------------------------------------------------
module tb;

    import lcdc_pkg::*;
    import lcdc_tb_pkg::*;

    localparam int ITEMS_PER_PHASE = 650;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   bus_access;
    logic    done;
    result_t result;
    int      errors;
    int      outstanding;
    int      sent;
    int      gap_pct;

    lcd_controller_command_and_ram_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .bus_access (bus_access),
        .done       (done),
        .result     (result)
    );

    lcd_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .bus_access  (bus_access),
        .done        (done),
        .result      (result),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // Clock generation
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Run limit: the RAM sweep plus all beats with long gaps, many times over
    initial
    begin
        #2_000_000;
        $display("[lcd_controller_command_and_ram_unit] ERROR");
        $finish;
    end

    // Present one beat after random idle cycles and hold it until accepted
    task automatic issue(input logic rd, input logic cmd, input logic [7:0] val);
        item_t acc;
        acc.mode       = rd;
        acc.reg_select = cmd;
        acc.write_data = val;
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            start      <= 1'b0;
            bus_access <= item_t'($urandom);
        end
        @(negedge clk);
        start      <= 1'b1;
        bus_access <= acc;
        do @(posedge clk); while (busy);
        sent++;
    endtask

    task automatic send_cmd(input logic [7:0] val);
        issue(1'b0, 1'b1, val);
    endtask

    task automatic send_data(input logic [7:0] val);
        issue(1'b0, 1'b0, val);
    endtask

    task automatic read_ram();
        issue(1'b1, 1'b0, 8'($urandom));
    endtask

    task automatic read_status();
        issue(1'b1, 1'b1, 8'($urandom));
    endtask

    // Hold the sender off until every status beat is back
    task automatic drain();
        do
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        while (outstanding != 0);
    endtask

    // Move the cursor: pages past the last clamp, columns lean toward the end
    task automatic place_cursor();
        logic [3:0] pg;
        logic [7:0] col;
        pg  = ($urandom_range(99) < 80) ? 4'($urandom_range(DATA_PAGES_DEF))
                                        : 4'($urandom_range(15, DATA_PAGES_DEF + 1));
        case ($urandom_range(3))
            0:       col = 8'($urandom);
            1:       col = 8'($urandom_range(LAST_COLUMN_DEF, LAST_COLUMN_DEF - 12));
            default: col = 8'($urandom_range(LAST_COLUMN_DEF));
        endcase
        send_cmd(OPC_PAGE | pg);
        if ($urandom_range(1))
        begin
            send_cmd(OPC_COL_HI | col[7:4]);
            send_cmd(OPC_COL_LO | col[3:0]);
        end
        else
        begin
            send_cmd(OPC_COL_LO | col[3:0]);
            send_cmd(OPC_COL_HI | col[7:4]);
        end
    endtask

    // One random sequence, mostly well formed
    task automatic random_sequence();
        int         pick;
        int         n;
        logic [7:0] low;
        pick = $urandom_range(99);
        low  = 8'($urandom);
        n    = $urandom_range(12, 1);
        if (pick < 30)
        begin
            // write burst
            place_cursor();
            repeat (n) send_data(8'($urandom));
        end
        else if (pick < 50)
        begin
            // read-back burst
            place_cursor();
            repeat (n) read_ram();
        end
        else if (pick < 60)
        begin
            // read-modify-write: reads hold the column, writes advance it
            place_cursor();
            send_cmd(BYTE_RMW_BEGIN);
            repeat ($urandom_range(4, 1))
            begin
                read_ram();
                if ($urandom_range(3) == 0)
                    read_status();
                send_data(8'($urandom));
            end
            send_cmd(BYTE_RMW_END);
        end
        else if (pick < 68)
        begin
            // volume pair, sometimes with reads in between
            send_cmd(BYTE_VOLUME);
            if ($urandom_range(1))
                read_ram();
            if ($urandom_range(2) == 0)
                read_status();
            issue(1'b0, 1'($urandom), 8'($urandom));
        end
        else if (pick < 85)
        begin
            // one flag or register command
            case ($urandom_range(12))
                0:  send_cmd(OPC_DISPLAY | low[0]);
                1:  send_cmd(OPC_START_LINE | low[5:0]);
                2:  send_cmd(OPC_SEG_REV | low[0]);
                3:  send_cmd(OPC_ALL_ON | low[0]);
                4:  send_cmd(OPC_INVERT | low[0]);
                5:  send_cmd(OPC_BIAS | low[0]);
                6:  send_cmd(OPC_INDICATOR | low[0]);
                7:  send_cmd(OPC_RATIO | low[2:0]);
                8:  send_cmd(OPC_POWER | low[2:0]);
                9:  send_cmd(OPC_COM_REV | low[3:0]);
                10: send_cmd(OPC_COL_LO | low[3:0]);
                11: send_cmd(OPC_COL_HI | low[3:0]);
                default: send_cmd(OPC_PAGE | low[3:0]);
            endcase
        end
        else
        begin
            // noise: any access on any port
            issue(1'($urandom), 1'($urandom), 8'($urandom));
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        bus_access = '0;
        sent       = 0;
        gap_pct    = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening
        read_status();
        read_ram();
        send_cmd(OPC_DISPLAY | 8'h01);
        send_cmd(OPC_START_LINE | 8'h3F);
        send_cmd(OPC_COL_HI | 8'h0F);           // column saturates at the last one
        send_cmd(OPC_PAGE | 8'h0F);             // page saturates at the indicator page
        send_data(8'hFF);                       // indicator page keeps bit 0
        send_data(8'hFE);                       // column stays at the end
        read_ram();
        send_cmd(OPC_PAGE);
        send_cmd(OPC_COL_HI);
        send_cmd(OPC_COL_LO);
        send_data(8'hFF);
        send_data(8'h00);
        send_cmd(OPC_COL_LO);
        send_cmd(BYTE_RMW_BEGIN);
        read_ram();
        read_ram();
        send_cmd(BYTE_RMW_END);
        read_ram();
        send_cmd(BYTE_VOLUME);
        read_ram();                             // pending volume survives a read
        send_data(8'hFF);                       // consumed as volume
        send_cmd(BYTE_VOLUME);
        send_cmd(8'h00);                        // consumed as volume, not a column
        send_cmd(OPC_IGNORED);
        send_cmd(OPC_SEG_REV | 8'h01);
        send_cmd(OPC_ALL_ON | 8'h01);
        send_cmd(OPC_COM_REV | 8'h08);
        send_cmd(OPC_DISPLAY);
        drain();

        // Random phases: no gaps, heavy gaps, light gaps
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       gap_pct = 0;
                1:       gap_pct = 63;
                default: gap_pct = 31;
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
                random_sequence();
            drain();
        end

        // Let any stray beat surface
        repeat (10) @(negedge clk);
        if (errors == 0 && outstanding == 0)
            $display("[lcd_controller_command_and_ram_unit] OK");
        else
            $display("[lcd_controller_command_and_ram_unit] ERROR");
        $finish;
    end

endmodule
